[rtl/btpc_pkg.sv]
// shared constants and types for the barometric compensation pipeline
package btpc_pkg;

    localparam int RAW_W   = 20;
    localparam int TC_W    = 20;
    localparam int PRESS_W = 32;
    localparam int NUM_W   = 81;
    localparam int DEN_W   = 44;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_COEFS_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_COEFS_MID = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_COEF_HIGH = 2'd3;

    typedef struct packed {
        logic signed [TC_W-1:0] tc;
        logic                   qneg;
        logic                   dbz;
    } btpc_side_t;

endpackage

[rtl/btpc_div.sv]
// pipelined restoring divider, one quotient bit per stage
module btpc_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_vld,
    input  logic [btpc_pkg::NUM_W-1:0]      num,
    input  logic [btpc_pkg::DEN_W-1:0]      den,
    input  btpc_pkg::btpc_side_t            side_in,
    output logic                            out_vld,
    output logic [btpc_pkg::NUM_W-1:0]      quot,
    output btpc_pkg::btpc_side_t            side_out
);

    localparam int NW = btpc_pkg::NUM_W;
    localparam int DW = btpc_pkg::DEN_W;

    logic                 vld_reg  [1:NW];
    logic [DW-1:0]        rem_reg  [1:NW];
    logic [NW-1:0]        nq_reg   [1:NW];
    logic [DW-1:0]        den_reg  [1:NW];
    btpc_pkg::btpc_side_t side_reg [1:NW];

    for (genvar i = 0; i < NW; i++)
    begin : g_step
        logic                 vld_cur;
        logic [DW-1:0]        rem_cur;
        logic [NW-1:0]        nq_cur;
        logic [DW-1:0]        den_cur;
        btpc_pkg::btpc_side_t side_cur;
        logic [DW:0]          trial;
        logic [DW:0]          diff;
        logic                 ge;

        if (i == 0)
        begin : g_first
            assign vld_cur  = in_vld;
            assign rem_cur  = '0;
            assign nq_cur   = num;
            assign den_cur  = den;
            assign side_cur = side_in;
        end
        else
        begin : g_rest
            assign vld_cur  = vld_reg[i];
            assign rem_cur  = rem_reg[i];
            assign nq_cur   = nq_reg[i];
            assign den_cur  = den_reg[i];
            assign side_cur = side_reg[i];
        end

        assign trial = {rem_cur, nq_cur[NW-1]};
        assign diff  = trial - {1'b0, den_cur};
        assign ge    = (trial >= {1'b0, den_cur});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                nq_reg[i+1]   <= {nq_cur[NW-2:0], ge};
                den_reg[i+1]  <= den_cur;
                side_reg[i+1] <= side_cur;
            end
        end
    end

    assign out_vld  = vld_reg[NW];
    assign quot     = nq_reg[NW];
    assign side_out = side_reg[NW];

endmodule

[rtl/baro_temp_pressure_compensation.sv]
// top level: temperature and pressure compensation pipeline
//
//  channel   signals                                        direction
//  cfg       cfg_valid cfg_ready cfg_index cfg_data          write
//  in        in_valid in_ready raw_temperature raw_pressure  request in
//  out       out_valid out_ready temperature_centi           request out
//            pressure_q24_8 divide_by_zero
//
//  one request per cycle while no result waits at the output; 11 front
//  stages, 81 divider stages and 8 back stages
//  the whole pipe holds while a result waits at the output; a one-entry
//  skid at the input still takes a request during such a hold
//  reset clears the valid bits, the skid and the coefficients
module baro_temp_pressure_compensation
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [btpc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [btpc_pkg::RAW_W-1:0]            raw_temperature,
    input  logic [btpc_pkg::RAW_W-1:0]            raw_pressure,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [btpc_pkg::TC_W-1:0]      temperature_centi,
    output logic [btpc_pkg::PRESS_W-1:0]          pressure_q24_8,
    output logic                                  divide_by_zero
);

    localparam int NW = btpc_pkg::NUM_W;
    localparam int DW = btpc_pkg::DEN_W;
    localparam int TW = btpc_pkg::TC_W;
    localparam int RW = btpc_pkg::RAW_W;

    // coefficients
    logic [47:0] temp_coefs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_mid_reg;
    logic [15:0] press_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coefs_reg <= '0;
            press_low_reg  <= '0;
            press_mid_reg  <= '0;
            press_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                btpc_pkg::REG_TEMP_COEFS:      temp_coefs_reg <= cfg_data[47:0];
                btpc_pkg::REG_PRESS_COEFS_LOW: press_low_reg  <= cfg_data;
                btpc_pkg::REG_PRESS_COEFS_MID: press_mid_reg  <= cfg_data;
                btpc_pkg::REG_PRESS_COEF_HIGH: press_high_reg <= cfg_data[15:0];
                default:                       temp_coefs_reg <= temp_coefs_reg;
            endcase
        end
    end

    logic [15:0]        t1u;
    logic signed [15:0] t2, t3;
    logic signed [16:0] p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1u = temp_coefs_reg[15:0];
    assign t2  = temp_coefs_reg[31:16];
    assign t3  = temp_coefs_reg[47:32];
    assign p1  = $signed({1'b0, press_low_reg[15:0]});
    assign p2  = press_low_reg[31:16];
    assign p3  = press_low_reg[47:32];
    assign p4  = press_low_reg[63:48];
    assign p5  = press_mid_reg[15:0];
    assign p6  = press_mid_reg[31:16];
    assign p7  = press_mid_reg[47:32];
    assign p8  = press_mid_reg[63:48];
    assign p9  = press_high_reg;

    // flow control
    logic          adv;
    logic          skid_vld_reg;
    logic [RW-1:0] skid_t_reg, skid_p_reg;

    assign adv      = !out_valid || out_ready;
    assign in_ready = !skid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            skid_vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!adv && in_valid && in_ready)
        begin
            skid_t_reg <= raw_temperature;
            skid_p_reg <= raw_pressure;
        end
    end

    // front valid chain
    logic [11:1] pre_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= '0;
        end
        else if (adv)
        begin
            pre_vld_reg <= {pre_vld_reg[10:1], skid_vld_reg | in_valid};
        end
    end

    // stage registers
    logic [RW-1:0]        s1_t_reg, s1_p_reg;
    logic signed [33:0]   s2_at2_reg;
    logic [31:0]          s2_bb_reg;
    logic [RW-1:0]        s2_p_reg;
    logic signed [22:0]   s3_at2s_reg;
    logic signed [36:0]   s3_bbt3_reg;
    logic [RW-1:0]        s3_p_reg;
    logic signed [23:0]   s4_tf_reg;
    logic [RW-1:0]        s4_p_reg;
    logic signed [TW-1:0] s5_tc_reg;
    logic signed [24:0]   s5_x_reg;
    logic [RW-1:0]        s5_p_reg;
    logic signed [49:0]   s6_xx_reg;
    logic signed [40:0]   s6_xp5_reg, s6_xp2_reg;
    logic signed [TW-1:0] s6_tc_reg;
    logic [RW-1:0]        s6_p_reg;
    logic signed [65:0]   s7_xxp6_reg, s7_xxp3_reg;
    logic signed [40:0]   s7_xp5_reg, s7_xp2_reg;
    logic signed [TW-1:0] s7_tc_reg;
    logic [RW-1:0]        s7_p_reg;
    logic signed [67:0]   s8_v2_reg;
    logic signed [59:0]   s8_v1a_reg;
    logic signed [TW-1:0] s8_tc_reg;
    logic [RW-1:0]        s8_p_reg;
    logic signed [76:0]   s9_v1p_reg;
    logic signed [68:0]   s9_num1_reg;
    logic signed [TW-1:0] s9_tc_reg;
    logic signed [DW-1:0] s10_v1_reg;
    logic signed [NW-1:0] s10_num_reg;
    logic signed [TW-1:0] s10_tc_reg;
    logic [NW-1:0]        s11_num_reg;
    logic [DW-1:0]        s11_den_reg;
    btpc_pkg::btpc_side_t s11_side_reg;

    // stage logic
    logic signed [17:0] a_w;
    logic signed [16:0] b_w;
    logic signed [33:0] bb_full;
    logic signed [33:0] at2_sh;
    logic signed [36:0] bbt3_sh;
    logic signed [26:0] tf5;
    logic signed [26:0] tc_sh;
    logic signed [65:0] xxp3_sh;
    logic signed [21:0] pdiff;
    logic signed [76:0] v1p_sh;

    assign a_w     = $signed({1'b0, s1_t_reg[19:3]}) - $signed({1'b0, t1u, 1'b0});
    assign b_w     = $signed({1'b0, s1_t_reg[19:4]}) - $signed({1'b0, t1u});
    assign bb_full = 34'(b_w) * 34'(b_w);
    assign at2_sh  = s2_at2_reg >>> 11;
    assign bbt3_sh = s3_bbt3_reg >>> 14;
    assign tf5     = 27'(s4_tf_reg) * 27'sd5 + 27'sd128;
    assign tc_sh   = tf5 >>> 8;
    assign xxp3_sh = s7_xxp3_reg >>> 8;
    assign pdiff   = 22'sd1048576 - $signed({2'b0, s8_p_reg});
    assign v1p_sh  = s9_v1p_reg >>> 33;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_t_reg    <= skid_vld_reg ? skid_t_reg : raw_temperature;
            s1_p_reg    <= skid_vld_reg ? skid_p_reg : raw_pressure;

            s2_at2_reg  <= 34'(a_w) * 34'(t2);
            s2_bb_reg   <= bb_full[31:0];
            s2_p_reg    <= s1_p_reg;

            s3_at2s_reg <= at2_sh[22:0];
            s3_bbt3_reg <= 37'($signed({1'b0, s2_bb_reg[31:12]})) * 37'(t3);
            s3_p_reg    <= s2_p_reg;

            s4_tf_reg   <= 24'(s3_at2s_reg) + 24'($signed(bbt3_sh[22:0]));
            s4_p_reg    <= s3_p_reg;

            s5_tc_reg   <= tc_sh[TW-1:0];
            s5_x_reg    <= 25'(s4_tf_reg) - 25'sd128000;
            s5_p_reg    <= s4_p_reg;

            s6_xx_reg   <= 50'(s5_x_reg) * 50'(s5_x_reg);
            s6_xp5_reg  <= 41'(s5_x_reg) * 41'(p5);
            s6_xp2_reg  <= 41'(s5_x_reg) * 41'(p2);
            s6_tc_reg   <= s5_tc_reg;
            s6_p_reg    <= s5_p_reg;

            s7_xxp6_reg <= 66'(s6_xx_reg) * 66'(p6);
            s7_xxp3_reg <= 66'(s6_xx_reg) * 66'(p3);
            s7_xp5_reg  <= s6_xp5_reg;
            s7_xp2_reg  <= s6_xp2_reg;
            s7_tc_reg   <= s6_tc_reg;
            s7_p_reg    <= s6_p_reg;

            s8_v2_reg   <= 68'(s7_xxp6_reg) + (68'(s7_xp5_reg) <<< 17)
                           + (68'(p4) <<< 35);
            s8_v1a_reg  <= 60'($signed(xxp3_sh[57:0])) + (60'(s7_xp2_reg) <<< 12)
                           + (60'sd1 <<< 47);
            s8_tc_reg   <= s7_tc_reg;
            s8_p_reg    <= s7_p_reg;

            s9_v1p_reg  <= 77'(s8_v1a_reg) * 77'(p1);
            s9_num1_reg <= (69'(pdiff) <<< 31) - 69'(s8_v2_reg);
            s9_tc_reg   <= s8_tc_reg;

            s10_v1_reg  <= v1p_sh[DW-1:0];
            s10_num_reg <= 81'(s9_num1_reg) * 81'sd3125;
            s10_tc_reg  <= s9_tc_reg;

            s11_num_reg       <= s10_num_reg[NW-1] ? NW'(-s10_num_reg) : NW'(s10_num_reg);
            s11_den_reg       <= s10_v1_reg[DW-1] ? DW'(-s10_v1_reg) : DW'(s10_v1_reg);
            s11_side_reg.tc   <= s10_tc_reg;
            s11_side_reg.qneg <= s10_num_reg[NW-1] ^ s10_v1_reg[DW-1];
            s11_side_reg.dbz  <= (s10_v1_reg == '0);
        end
    end

    // divider
    logic                 div_vld;
    logic [NW-1:0]        div_q;
    btpc_pkg::btpc_side_t div_side;

    btpc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (pre_vld_reg[11]),
        .num      (s11_num_reg),
        .den      (s11_den_reg),
        .side_in  (s11_side_reg),
        .out_vld  (div_vld),
        .quot     (div_q),
        .side_out (div_side)
    );

    // back valid chain
    logic [8:1] post_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_vld_reg <= '0;
        end
        else if (adv)
        begin
            post_vld_reg <= {post_vld_reg[7:1], div_vld};
        end
    end

    // back stages
    logic signed [60:0]   e1_p_reg, e2_p_reg, e3_p_reg, e4_p_reg, e5_p_reg, e6_p_reg;
    logic                 e1_big_reg, e2_big_reg, e3_big_reg, e4_big_reg;
    logic                 e5_big_reg, e6_big_reg, e7_big_reg;
    logic                 e1_low_reg, e2_low_reg, e3_low_reg, e4_low_reg;
    logic                 e5_low_reg, e6_low_reg, e7_low_reg;
    logic                 e1_dbz_reg, e2_dbz_reg, e3_dbz_reg, e4_dbz_reg;
    logic                 e5_dbz_reg, e6_dbz_reg, e7_dbz_reg;
    logic signed [TW-1:0] e1_tc_reg, e2_tc_reg, e3_tc_reg, e4_tc_reg;
    logic signed [TW-1:0] e5_tc_reg, e6_tc_reg, e7_tc_reg;
    logic [47:0]          e2_mps_reg;
    logic signed [76:0]   e2_p8p_reg, e3_p8p_reg, e4_p8p_reg, e5_p8p_reg, e6_p8p_reg;
    logic [47:0]          e3_hh_reg, e3_hl_reg, e3_ll_reg;
    logic [95:0]          e4_sq_reg;
    logic signed [48:0]   e5_pp0_reg, e5_pp1_reg, e5_pp2_reg;
    logic signed [113:0]  e6_quad_reg;
    logic signed [89:0]   e7_s_reg;

    logic [NW:0]          pq_w;
    logic signed [60:0]   ps_full;
    logic signed [47:0]   ps_w;
    logic signed [113:0]  quad_sh;
    logic signed [76:0]   p8p_sh;
    logic signed [89:0]   s_sh;
    logic signed [82:0]   r_w;
    logic [31:0]          press_w;

    assign pq_w    = div_side.qneg ? -{1'b0, div_q} : {1'b0, div_q};
    assign ps_full = e1_p_reg >>> 13;
    assign ps_w    = ps_full[47:0];
    assign quad_sh = e6_quad_reg >>> 25;
    assign p8p_sh  = e6_p8p_reg >>> 19;
    assign s_sh    = e7_s_reg >>> 8;
    assign r_w     = 83'($signed(s_sh[81:0])) + (83'(p7) <<< 4);

    always_comb
    begin
        if (e7_dbz_reg)
        begin
            press_w = '0;
        end
        else if (e7_big_reg)
        begin
            press_w = e7_low_reg ? '0 : '1;
        end
        else if (r_w[82])
        begin
            press_w = '0;
        end
        else if (|r_w[81:32])
        begin
            press_w = '1;
        end
        else
        begin
            press_w = r_w[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_p_reg    <= pq_w[60:0];
            e1_big_reg  <= |div_q[NW-1:60];
            e1_low_reg  <= (p9 != '0) ? p9[15] : div_side.qneg;
            e1_dbz_reg  <= div_side.dbz;
            e1_tc_reg   <= div_side.tc;

            e2_mps_reg  <= ps_w[47] ? 48'(-ps_w) : 48'(ps_w);
            e2_p8p_reg  <= 77'(e1_p_reg) * 77'(p8);
            e2_p_reg    <= e1_p_reg;
            e2_big_reg  <= e1_big_reg;
            e2_low_reg  <= e1_low_reg;
            e2_dbz_reg  <= e1_dbz_reg;
            e2_tc_reg   <= e1_tc_reg;

            e3_hh_reg   <= 48'(e2_mps_reg[47:24]) * 48'(e2_mps_reg[47:24]);
            e3_hl_reg   <= 48'(e2_mps_reg[47:24]) * 48'(e2_mps_reg[23:0]);
            e3_ll_reg   <= 48'(e2_mps_reg[23:0]) * 48'(e2_mps_reg[23:0]);
            e3_p8p_reg  <= e2_p8p_reg;
            e3_p_reg    <= e2_p_reg;
            e3_big_reg  <= e2_big_reg;
            e3_low_reg  <= e2_low_reg;
            e3_dbz_reg  <= e2_dbz_reg;
            e3_tc_reg   <= e2_tc_reg;

            e4_sq_reg   <= (96'(e3_hh_reg) << 48) + (96'(e3_hl_reg) << 25)
                           + 96'(e3_ll_reg);
            e4_p8p_reg  <= e3_p8p_reg;
            e4_p_reg    <= e3_p_reg;
            e4_big_reg  <= e3_big_reg;
            e4_low_reg  <= e3_low_reg;
            e4_dbz_reg  <= e3_dbz_reg;
            e4_tc_reg   <= e3_tc_reg;

            e5_pp0_reg  <= 49'($signed({1'b0, e4_sq_reg[31:0]})) * 49'(p9);
            e5_pp1_reg  <= 49'($signed({1'b0, e4_sq_reg[63:32]})) * 49'(p9);
            e5_pp2_reg  <= 49'($signed({1'b0, e4_sq_reg[95:64]})) * 49'(p9);
            e5_p8p_reg  <= e4_p8p_reg;
            e5_p_reg    <= e4_p_reg;
            e5_big_reg  <= e4_big_reg;
            e5_low_reg  <= e4_low_reg;
            e5_dbz_reg  <= e4_dbz_reg;
            e5_tc_reg   <= e4_tc_reg;

            e6_quad_reg <= 114'(e5_pp0_reg) + (114'(e5_pp1_reg) <<< 32)
                           + (114'(e5_pp2_reg) <<< 64);
            e6_p8p_reg  <= e5_p8p_reg;
            e6_p_reg    <= e5_p_reg;
            e6_big_reg  <= e5_big_reg;
            e6_low_reg  <= e5_low_reg;
            e6_dbz_reg  <= e5_dbz_reg;
            e6_tc_reg   <= e5_tc_reg;

            e7_s_reg    <= 90'(e6_p_reg) + 90'($signed(quad_sh[88:0]))
                           + 90'($signed(p8p_sh[57:0]));
            e7_big_reg  <= e6_big_reg;
            e7_low_reg  <= e6_low_reg;
            e7_dbz_reg  <= e6_dbz_reg;
            e7_tc_reg   <= e6_tc_reg;

            temperature_centi <= e7_tc_reg;
            pressure_q24_8    <= press_w;
            divide_by_zero    <= e7_dbz_reg;
        end
    end

    assign out_valid = post_vld_reg[8];

endmodule

[sim/testbench.sv]
// self-checking testbench for the barometric temperature and pressure compensation pipeline
`timescale 1ns / 100ps

module testbench;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic signed [btpc_pkg::TC_W-1:0] tc;
        logic [btpc_pkg::PRESS_W-1:0]     press;
        logic                             dbz;
    } comp_t;

    typedef struct {
        logic [btpc_pkg::RAW_W-1:0] rt;
        logic [btpc_pkg::RAW_W-1:0] rp;
        logic                       typed;
        comp_t                      res;
    } row_t;

    typedef struct {
        logic  typed;
        comp_t res;
    } pend_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [btpc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [btpc_pkg::CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [btpc_pkg::RAW_W-1:0] raw_temperature;
    logic [btpc_pkg::RAW_W-1:0] raw_pressure;
    logic out_valid;
    logic out_ready;
    logic signed [btpc_pkg::TC_W-1:0] temperature_centi;
    logic [btpc_pkg::PRESS_W-1:0] pressure_q24_8;
    logic divide_by_zero;

    logic [47:0] temp_coefs;
    logic [63:0] press_low;
    logic [63:0] press_mid;
    logic [15:0] press_high;

    pend_t sent_q[$];
    comp_t comp_q[$];
    bit    failed;
    bit    no_idle;
    int    quiet_cycles;

    baro_temp_pressure_compensation dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
        .out_valid(out_valid), .out_ready(out_ready),
        .temperature_centi(temperature_centi), .pressure_q24_8(pressure_q24_8),
        .divide_by_zero(divide_by_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic comp_t compensate(logic [btpc_pkg::RAW_W-1:0] rt,
                                         logic [btpc_pkg::RAW_W-1:0] rp);
        comp_t r;
        longint adc_t, adc_p, t1, t2, t3, a, b, tf, tc;
        wide_t c1, c2, c3, c4, c5, c6, c7, c8, c9, one, x, xx, v1, v2, p, ps;
        adc_t = rt;
        adc_p = rp;
        t1 = temp_coefs[15:0];
        t2 = $signed(temp_coefs[31:16]);
        t3 = $signed(temp_coefs[47:32]);
        a = (adc_t >>> 3) - 2 * t1;
        b = (adc_t >>> 4) - t1;
        tf = ((a * t2) >>> 11) + ((((b * b) >>> 12) * t3) >>> 14);
        tc = (tf * 5 + 128) >>> 8;
        if (tc > 524287)
            tc = 524287;
        if (tc < -524288)
            tc = -524288;
        r.tc = tc[btpc_pkg::TC_W-1:0];
        c1 = press_low[15:0];
        c2 = $signed(press_low[31:16]);
        c3 = $signed(press_low[47:32]);
        c4 = $signed(press_low[63:48]);
        c5 = $signed(press_mid[15:0]);
        c6 = $signed(press_mid[31:16]);
        c7 = $signed(press_mid[47:32]);
        c8 = $signed(press_mid[63:48]);
        c9 = $signed(press_high);
        one = 1;
        x = tf - 128000;
        xx = x * x;
        v2 = xx * c6 + ((x * c5) <<< 17) + (c4 <<< 35);
        v1 = ((xx * c3) >>> 8) + ((x * c2) <<< 12);
        v1 = (((one <<< 47) + v1) * c1) >>> 33;
        if (v1 == 0)
        begin
            r.press = '0;
            r.dbz = 1'b1;
            return r;
        end
        p = 1048576 - adc_p;
        p = (((p <<< 31) - v2) * 3125) / v1;
        ps = p >>> 13;
        v1 = (c9 * ps * ps) >>> 25;
        v2 = (c8 * p) >>> 19;
        p = ((p + v1 + v2) >>> 8) + (c7 <<< 4);
        if (p < 0)
            r.press = '0;
        else if (p[191:32] != 0)
            r.press = '1;
        else
            r.press = p[31:0];
        r.dbz = 1'b0;
        return r;
    endfunction

    // accepted requests turn into expectations
    always @(posedge clk)
    begin
        pend_t pd;
        if (in_valid && in_ready)
        begin
            pd = sent_q.pop_front();
            comp_q.push_back(pd.typed ? pd.res : compensate(raw_temperature, raw_pressure));
        end
    end

    always @(posedge clk)
    begin
        comp_t e;
        if (out_valid && out_ready)
        begin
            if (comp_q.size() == 0)
            begin
                $display("%t unexpected result tc=%0d p=%0d dbz=%0d", $time,
                         temperature_centi, pressure_q24_8, divide_by_zero);
                failed = 1'b1;
            end
            else
            begin
                e = comp_q.pop_front();
                if (temperature_centi !== e.tc)
                begin
                    $display("%t temperature_centi expected %0d actual %0d", $time,
                             e.tc, temperature_centi);
                    failed = 1'b1;
                end
                if (pressure_q24_8 !== e.press)
                begin
                    $display("%t pressure_q24_8 expected %0d actual %0d", $time,
                             e.press, pressure_q24_8);
                    failed = 1'b1;
                end
                if (divide_by_zero !== e.dbz)
                begin
                    $display("%t divide_by_zero expected %0d actual %0d", $time,
                             e.dbz, divide_by_zero);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side stalls
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 7);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic cfg_write(logic [btpc_pkg::CFG_IDX_W-1:0] idx,
                             logic [btpc_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            btpc_pkg::REG_TEMP_COEFS:      temp_coefs = val[47:0];
            btpc_pkg::REG_PRESS_COEFS_LOW: press_low  = val;
            btpc_pkg::REG_PRESS_COEFS_MID: press_mid  = val;
            btpc_pkg::REG_PRESS_COEF_HIGH: press_high = val[15:0];
            default:                       ;
        endcase
    endtask

    task automatic load_coefs(logic [63:0] tv, logic [63:0] lv, logic [63:0] mv,
                              logic [63:0] hv);
        while (comp_q.size() != 0 || sent_q.size() != 0)
            @(posedge clk);
        cfg_write(btpc_pkg::REG_TEMP_COEFS, tv);
        cfg_write(btpc_pkg::REG_PRESS_COEFS_LOW, lv);
        cfg_write(btpc_pkg::REG_PRESS_COEFS_MID, mv);
        cfg_write(btpc_pkg::REG_PRESS_COEF_HIGH, hv);
        cfg_valid <= 1'b0;
    endtask

    task automatic send(logic [btpc_pkg::RAW_W-1:0] rt, logic [btpc_pkg::RAW_W-1:0] rp,
                        logic typed, comp_t res);
        int n;
        pend_t pd;
        n = no_idle ? 0 : $urandom_range(0, 7);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        pd.typed = typed;
        pd.res = res;
        sent_q.push_back(pd);
        in_valid <= 1'b1;
        raw_temperature <= rt;
        raw_pressure <= rp;
        do @(posedge clk); while (!in_ready);
    endtask

    row_t rows[$];
    comp_t zero_dbz = '{tc: 0, press: 0, dbz: 1'b1};
    comp_t none = '{tc: 0, press: 0, dbz: 1'b0};

    initial
    begin
        logic [63:0] tv, lv, mv, hv;
        logic [btpc_pkg::RAW_W-1:0] rt, rp;
        failed = 1'b0;
        no_idle = 1'b0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        raw_temperature = '0;
        raw_pressure = '0;
        temp_coefs = '0;
        press_low = '0;
        press_mid = '0;
        press_high = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all coefficients zero after reset: zero temperature, divisor zero
        rows = '{
            '{20'h00000, 20'h00000, 1'b1, zero_dbz},
            '{20'hFFFFF, 20'hFFFFF, 1'b1, zero_dbz},
            '{20'hFFFFF, 20'h00000, 1'b1, zero_dbz},
            '{20'h00000, 20'hFFFFF, 1'b1, zero_dbz},
            '{20'hAAAAA, 20'h55555, 1'b1, zero_dbz},
            '{20'h55555, 20'hAAAAA, 1'b1, zero_dbz}
        };
        foreach (rows[i])
            send(rows[i].rt, rows[i].rp, rows[i].typed, rows[i].res);
        in_valid <= 1'b0;

        // nominal calibration
        load_coefs({16'hFC18, 16'd26435, 16'd27504}, {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                   {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 64'd6000);
        rows = '{
            '{20'd519888, 20'd415148, 1'b0, none},
            '{20'h00000, 20'h00000, 1'b0, none},
            '{20'hFFFFF, 20'hFFFFF, 1'b0, none},
            '{20'h00000, 20'hFFFFF, 1'b0, none},
            '{20'hFFFFF, 20'h00000, 1'b0, none},
            '{20'd519888, 20'h00000, 1'b0, none},
            '{20'd519888, 20'hFFFFF, 1'b0, none},
            '{20'h80000, 20'h80000, 1'b0, none}
        };
        foreach (rows[i])
            send(rows[i].rt, rows[i].rp, rows[i].typed, rows[i].res);
        in_valid <= 1'b0;

        // P1 alone nonzero: divisor fixed, pressure saturates for a raw pressure of zero
        load_coefs(64'd0, 64'd1, 64'd0, 64'd0);
        send(20'd0, 20'd0, 1'b0, none);
        send(20'hFFFFF, 20'hFFFFF, 1'b0, none);
        in_valid <= 1'b0;

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0, 6:
                begin
                    tv = {16'(16'hFC18 + $urandom_range(0, 200)),
                          16'(16'd26435 + $urandom_range(0, 400)),
                          16'(16'd27504 + $urandom_range(0, 400))};
                    lv = {16'd2855, 16'd3024, 16'hD643,
                          16'(16'd36477 + $urandom_range(0, 400))};
                    mv = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
                    hv = {$urandom, $urandom};
                end
                2: begin tv = '1; lv = '1; mv = '1; hv = '1; end
                3:
                begin
                    tv = {16'h8000, 16'h8000, 16'h0000};
                    lv = {16'h8000, 16'h8000, 16'h8000, 16'hFFFF};
                    mv = {4{16'h8000}};
                    hv = 64'h8000;
                end
                4:
                begin
                    tv = {16'h7FFF, 16'h7FFF, 16'hFFFF};
                    lv = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
                    mv = {4{16'h7FFF}};
                    hv = 64'h7FFF;
                end
                5:
                begin
                    tv = {$urandom, $urandom};
                    lv = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000;
                    mv = {$urandom, $urandom};
                    hv = {$urandom, $urandom};
                end
                default:
                begin
                    tv = {$urandom, $urandom};
                    lv = {$urandom, $urandom};
                    mv = {$urandom, $urandom};
                    hv = {$urandom, $urandom};
                end
            endcase
            load_coefs(tv, lv, mv, hv);
            no_idle = (ph % 3 == 1);
            for (int k = 0; k < 54; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        rt = 20'($urandom);
                        rp = 20'($urandom);
                    end
                    3:
                    begin
                        rt = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
                        rp = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
                    end
                    default:
                    begin
                        rt = 20'($urandom_range(400000, 640000));
                        rp = 20'($urandom_range(200000, 700000));
                    end
                endcase
                send(rt, rp, 1'b0, none);
            end
            in_valid <= 1'b0;
        end

        while (comp_q.size() != 0 || sent_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
